// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/pvd_pkg.sv -----
`default_nettype none
package pvd_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 64;
  localparam int LEN_W   = 4;
  localparam int COUNT_W = 4;
  localparam int LANES   = VALUE_W / BYTE_W;
  localparam int LANE_W  = $clog2(LANES);
  localparam int OUT_DATA_W = ((VALUE_W + LEN_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0]  HEAD_TWO_BYTE  = 8'h80;
  localparam logic [BYTE_W-1:0]  HEAD_FOUR_BYTE = 8'hC0;
  localparam logic [BYTE_W-1:0]  HEAD_NINE_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0]  SIX_BIT_MASK   = 8'h3F;

  localparam logic [COUNT_W-1:0] MAX_TAIL_BYTES = 4'd8;

  localparam logic [LEN_W-1:0]   LEN_ONE  = 4'd1;
  localparam logic [LEN_W-1:0]   LEN_TWO  = 4'd2;
  localparam logic [LEN_W-1:0]   LEN_FOUR = 4'd4;
  localparam logic [LEN_W-1:0]   LEN_NINE = 4'd9;

  // One decoded integer as it leaves the decode step.
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;
  } pvd_result_t;

endpackage
`default_nettype wire

// ----- rtl/core/pvd_in_stage.sv -----
`default_nettype none
module pvd_in_stage
  import pvd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,
  input  wire logic              take,
  output logic                   byte_valid,
  output logic [BYTE_W-1:0]      byte_data
);

  // The register refills in the same cycle that its byte is consumed.
  assign s_tready = !byte_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_tready) begin
      byte_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      byte_data <= s_tdata;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pvd_step.sv -----
`default_nettype none
module pvd_step
  import pvd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              commit,
  output pvd_result_t            result
);

  logic [COUNT_W-1:0] bytes_left, bytes_left_next;
  logic               little_endian_form, little_endian_form_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [LEN_W-1:0]   length_so_far, length_so_far_next;

  logic               at_head;
  logic [LANE_W-1:0]  lane;
  logic [VALUE_W-1:0] merged;
  logic [COUNT_W-1:0] left_dec;
  logic [LEN_W-1:0]   len_inc;

  assign at_head  = (bytes_left == '0) || (bytes_left > MAX_TAIL_BYTES);
  assign lane     = LANE_W'(MAX_TAIL_BYTES - bytes_left);
  assign left_dec = bytes_left - COUNT_W'(1);
  assign len_inc  = length_so_far + LEN_W'(1);

  always_comb begin
    merged = accumulator;
    if (little_endian_form) begin
      for (int i = 0; i < LANES; i++) begin
        if (lane == LANE_W'(i)) begin
          merged[i*BYTE_W +: BYTE_W] = accumulator[i*BYTE_W +: BYTE_W] | in_byte;
        end
      end
    end else begin
      merged = {accumulator[VALUE_W-BYTE_W-1:0], in_byte};
    end
  end

  always_comb begin
    bytes_left_next         = bytes_left;
    little_endian_form_next = little_endian_form;
    accumulator_next        = accumulator;
    length_so_far_next      = length_so_far;
    result.valid            = 1'b0;
    result.value            = merged;
    result.length           = len_inc;
    if (at_head) begin
      bytes_left_next    = '0;
      length_so_far_next = LEN_ONE;
      if (in_byte < HEAD_TWO_BYTE) begin
        length_so_far_next = '0;
        result.valid       = 1'b1;
        result.value       = VALUE_W'(in_byte);
        result.length      = LEN_ONE;
      end else if (in_byte < HEAD_FOUR_BYTE) begin
        accumulator_next        = VALUE_W'(in_byte & SIX_BIT_MASK);
        bytes_left_next         = COUNT_W'(1);
        little_endian_form_next = 1'b0;
      end else if (in_byte < HEAD_NINE_BYTE) begin
        accumulator_next        = VALUE_W'(in_byte & SIX_BIT_MASK);
        bytes_left_next         = COUNT_W'(3);
        little_endian_form_next = 1'b0;
      end else begin
        accumulator_next        = '0;
        bytes_left_next         = MAX_TAIL_BYTES;
        little_endian_form_next = 1'b1;
      end
    end else begin
      bytes_left_next    = left_dec;
      accumulator_next   = merged;
      length_so_far_next = len_inc;
      if (left_dec == '0) begin
        result.valid            = 1'b1;
        accumulator_next        = '0;
        little_endian_form_next = 1'b0;
        length_so_far_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left         <= '0;
      little_endian_form <= 1'b0;
      accumulator        <= '0;
      length_so_far      <= '0;
    end else if (commit) begin
      bytes_left         <= bytes_left_next;
      little_endian_form <= little_endian_form_next;
      accumulator        <= accumulator_next;
      length_so_far      <= length_so_far_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pvd_out_stage.sv -----
`default_nettype none
module pvd_out_stage
  import pvd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pvd_result_t           result,
  input  wire logic                  load,
  output logic                       space,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  assign space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (space) begin
      m_tvalid <= load && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load && result.valid) begin
      m_tdata <= OUT_DATA_W'({result.length, result.value});
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/prefix_varint_decoder.sv -----
`default_nettype none
// Decodes a stream of prefix-coded unsigned integers, one byte per item on the slave side,
// and emits one item per completed integer on the master side carrying the value and its
// encoded length (1, 2, 4 or 9 bytes). Heads below 0x80 are the value; 0x80-0xBF and
// 0xC0-0xFE carry six high bits followed by one or three big-endian bytes; 0xFF is followed
// by eight bytes, least significant first. Non-canonical forms decode without a flag.
// The block takes one byte every cycle while the result side keeps up. A byte passes an
// input register and one decode step into the result register. Bytes that do not finish
// an integer never wait on the result side; a finishing byte waits only while the result
// register holds an item that has not been taken.
module prefix_varint_decoder
  import pvd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [BYTE_W-1:0]     s_tdata,  // [7:0] in_byte
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata   // [63:0] decoded_value, [67:64] encoded_length
);

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_data;
  logic              take;
  logic              space;
  pvd_result_t       result;

  assign take = byte_valid && (!result.valid || space);

  pvd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  pvd_step u_step (
    .clk     (clk),
    .rst     (rst),
    .in_byte (byte_data),
    .commit  (take),
    .result  (result)
  );

  pvd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .load     (take),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// ----- rtl/core/pvd_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module pvd_checker
  import pvd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [BYTE_W-1:0]     s_tdata,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [OUT_DATA_W-1:0] m_tdata
);

  logic [LEN_W-1:0] out_len;
  logic             in_seen;

  assign out_len = m_tdata[VALUE_W +: LEN_W];
  assign in_seen = s_tvalid && s_tready && (s_tdata != '0 || s_tdata == '0);

  // A stalled result keeps its contents.
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  `ASSERT_IMPLY(a_len_code, clk, rst, m_tvalid,
    out_len == LEN_ONE || out_len == LEN_TWO || out_len == LEN_FOUR || out_len == LEN_NINE)

  // Short forms cannot carry more bits than their head and tail bytes hold.
  `ASSERT_IMPLY(a_short_range, clk, rst, m_tvalid && out_len == LEN_ONE,
    m_tdata[VALUE_W-1:7] == '0)
  `ASSERT_IMPLY(a_mid_range, clk, rst, m_tvalid && (out_len == LEN_TWO || out_len == LEN_FOUR),
    m_tdata[VALUE_W-1:30] == '0 && (out_len == LEN_FOUR || m_tdata[29:14] == '0))

  // A result needs a byte to have been accepted before it first shows.
  `ASSERT_IMPLY(a_cause, clk, rst, $rose(m_tvalid), $past(in_seen, 2))

endmodule

bind prefix_varint_decoder pvd_checker u_pvd_checker (.*);
`default_nettype wire
